@@ src/jetp_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers for the julia escape-time pixel block
// no dependencies; imported by every module of the block
package jetp_pkg;

  localparam int ROWS_DEF    = 2048;
  localparam int COLUMNS_DEF = 2048;

  localparam int Q_W       = 32;
  localparam int COORD_W   = 11;
  localparam int LIMIT_W   = 9;
  localparam int COLOR_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int SAT_W     = 48;
  localparam int PROD_W    = 64;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [LIMIT_W-1:0] MAX_ITER  = 9'd256;
  localparam logic [Q_W-1:0]     FOUR_Q24  = 32'h0400_0000;
  localparam longint             ONE_Q24   = 64'sd16777216;

  localparam logic signed [Q_W-1:0] C_REAL_RST   = -32'sd6710886;
  localparam logic signed [Q_W-1:0] C_IMAG_RST   = 32'sd10066330;
  localparam logic signed [Q_W-1:0] X_ORIGIN_RST = -32'sd8388608;
  localparam logic signed [Q_W-1:0] Y_ORIGIN_RST = -32'sd8388608;

  localparam logic signed [SAT_W-1:0] SAT_HI = 48'sh0000_7FFF_FFFF;
  localparam logic signed [SAT_W-1:0] SAT_LO = -48'sh0000_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_REAL     = 3'd0,
    CFG_C_IMAG     = 3'd1,
    CFG_X_ORIGIN   = 3'd2,
    CFG_Y_ORIGIN   = 3'd3,
    CFG_X_STEP     = 3'd4,
    CFG_Y_STEP     = 3'd5,
    CFG_ITER_LIMIT = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } core_state_t;

  typedef struct packed {
    logic signed [Q_W-1:0] c_real;
    logic signed [Q_W-1:0] c_imag;
    logic signed [Q_W-1:0] x_origin;
    logic signed [Q_W-1:0] y_origin;
    logic signed [Q_W-1:0] x_step;
    logic signed [Q_W-1:0] y_step;
    logic [LIMIT_W-1:0]    iter_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [Q_W-1:0] zr;
    logic signed [Q_W-1:0] zi;
  } start_pt_t;

  typedef struct packed {
    logic      valid;
    start_pt_t pt;
  } queue_head_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[Q_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/jetp_front.sv @@
`timescale 1ns / 1ps
// front end: takes pixel transactions and computes the saturated start point
// depends on jetp_pkg
module jetp_front
  import jetp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [COORD_W-1:0]  pixel_row,
  input  logic [COORD_W-1:0]  pixel_column,
  input  cfg_t                cfg,
  input  logic                queue_full,
  output logic                busy,
  output logic                push,
  output start_pt_t           push_pt
);

  localparam int MUL_W = COORD_W + 1 + Q_W;

  logic                     s1_valid_r, s1_valid_nxt;
  logic signed [MUL_W-1:0]  prod_x_r, prod_x_nxt;
  logic signed [MUL_W-1:0]  prod_y_r, prod_y_nxt;
  logic                     accept;

  assign busy   = s1_valid_r || queue_full;
  assign accept = start && !busy;
  assign push   = s1_valid_r && !queue_full;

  always_comb begin
    prod_x_nxt = $signed({1'b0, pixel_column}) * $signed(cfg.x_step);
    prod_y_nxt = $signed({1'b0, pixel_row}) * $signed(cfg.y_step);
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // origin plus offset, clamped to q8.24
  always_comb begin
    push_pt.zr = sat32(SAT_W'(prod_x_r) + SAT_W'($signed(cfg.x_origin)));
    push_pt.zi = sat32(SAT_W'(prod_y_r) + SAT_W'($signed(cfg.y_origin)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
    end
  end

endmodule

@@ src/jetp_queue.sv @@
`timescale 1ns / 1ps
// short start-point queue between front end and iteration core
// depends on jetp_pkg
module jetp_queue
  import jetp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  start_pt_t   push_pt,
  input  logic        pop,
  output logic        full,
  output queue_head_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  start_pt_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == DEPTH_CNT);
  assign head.valid = (count_r != '0);
  assign head.pt    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != DEPTH_CNT || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue read while empty");

endmodule

@@ src/jetp_core.sv @@
`timescale 1ns / 1ps
// iteration core: one shared complex-square unit, multiply then update per step
// depends on jetp_pkg
module jetp_core
  import jetp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  queue_head_t         head,
  input  cfg_t                cfg,
  output logic                pop,
  output logic                out_strobe,
  output logic [COLOR_W-1:0]  out_color
);

  localparam int SQ_W  = Q_W - 1;
  localparam int DIF_W = Q_W + 2;

  core_state_t               state_r, state_nxt;
  logic signed [Q_W-1:0]     zr_r, zr_nxt;
  logic signed [Q_W-1:0]     zi_r, zi_nxt;
  logic [LIMIT_W-1:0]        count_r, count_nxt;
  logic [LIMIT_W-1:0]        limit_r, limit_nxt;
  logic signed [PROD_W-1:0]  p_rr_r, p_rr_nxt;
  logic signed [PROD_W-1:0]  p_ii_r, p_ii_nxt;
  logic signed [PROD_W-1:0]  p_ri_r, p_ri_nxt;
  logic                      strobe_r, strobe_nxt;
  logic [COLOR_W-1:0]        color_r, color_nxt;

  logic [SQ_W-1:0]           sr, si;
  logic [Q_W-1:0]            sq_sum;
  logic                      escaped;
  logic signed [DIF_W-1:0]   re_sum;
  logic signed [Q_W-1:0]     nzr, nzi;

  assign out_strobe = strobe_r;
  assign out_color  = color_r;

  // squares are non-negative: clamp when anything above bit 54 is set
  always_comb begin
    sr = (p_rr_r[PROD_W-1:55] != '0) ? '1 : p_rr_r[54:24];
    si = (p_ii_r[PROD_W-1:55] != '0) ? '1 : p_ii_r[54:24];
    sq_sum  = {1'b0, sr} + {1'b0, si};
    escaped = (sq_sum >= FOUR_Q24);
    re_sum  = $signed({3'b000, sr}) - $signed({3'b000, si}) + DIF_W'($signed(cfg.c_real));
    nzr = sat32(SAT_W'(re_sum));
    // 2*zr*zi in q8.24 is the product floored by 23
    nzi = sat32(SAT_W'($signed(p_ri_r[PROD_W-1:23])) + SAT_W'($signed(cfg.c_imag)));
  end

  always_comb begin
    state_nxt  = state_r;
    zr_nxt     = zr_r;
    zi_nxt     = zi_r;
    count_nxt  = count_r;
    limit_nxt  = limit_r;
    p_rr_nxt   = p_rr_r;
    p_ii_nxt   = p_ii_r;
    p_ri_nxt   = p_ri_r;
    strobe_nxt = 1'b0;
    color_nxt  = color_r;
    pop        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          zr_nxt    = head.pt.zr;
          zi_nxt    = head.pt.zi;
          count_nxt = '0;
          limit_nxt = (cfg.iter_limit > MAX_ITER) ? MAX_ITER : cfg.iter_limit;
          if (limit_nxt == '0) begin
            // zero limit: no step runs and the color is all ones
            strobe_nxt = 1'b1;
            color_nxt  = '1;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        p_rr_nxt  = zr_r * zr_r;
        p_ii_nxt  = zi_r * zi_r;
        p_ri_nxt  = zr_r * zi_r;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        zr_nxt    = nzr;
        zi_nxt    = nzi;
        count_nxt = count_r + 1'b1;
        if (escaped || count_nxt >= limit_r) begin
          strobe_nxt = 1'b1;
          color_nxt  = COLOR_W'(count_nxt - 1'b1);
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zr_r    <= zr_nxt;
    zi_r    <= zi_nxt;
    count_r <= count_nxt;
    limit_r <= limit_nxt;
    p_rr_r  <= p_rr_nxt;
    p_ii_r  <= p_ii_nxt;
    p_ri_r  <= p_ri_nxt;
    color_r <= color_nxt;
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (count_r < limit_r))
    else $error("iteration started at or past the limit");

  a_mul_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |=> (state_r == ST_UPD))
    else $error("multiply step not followed by update");

endmodule

@@ src/julia_escape_time_pixel_top.sv @@
`timescale 1ns / 1ps
// an accepted start passes the front-end product register and the start-point queue, then
// the multiply/update loop of the core's single complex-square unit once per step (0..256);
// pixels queue up meanwhile; busy holds the cycle after each accept and while queue is full
// out_strobe marks each color for exactly one cycle; the receiver cannot stall
// reset (sync, active low) empties the queue and loads default registers
module julia_escape_time_pixel_top
  import jetp_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [COORD_W-1:0]   in_pixel_row,
  input  logic [COORD_W-1:0]   in_pixel_column,
  output logic                 out_strobe,
  output logic [COLOR_W-1:0]   out_color,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_wdata
);

  localparam logic signed [Q_W-1:0] X_STEP_RST = Q_W'(ONE_Q24 / COLUMNS);
  localparam logic signed [Q_W-1:0] Y_STEP_RST = Q_W'(ONE_Q24 / ROWS);

  cfg_t        cfg_r, cfg_nxt;
  logic        queue_full;
  logic        push;
  logic        pop;
  start_pt_t   push_pt;
  queue_head_t head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_C_REAL:     cfg_nxt.c_real     = cfg_wdata;
        CFG_C_IMAG:     cfg_nxt.c_imag     = cfg_wdata;
        CFG_X_ORIGIN:   cfg_nxt.x_origin   = cfg_wdata;
        CFG_Y_ORIGIN:   cfg_nxt.y_origin   = cfg_wdata;
        CFG_X_STEP:     cfg_nxt.x_step     = cfg_wdata;
        CFG_Y_STEP:     cfg_nxt.y_step     = cfg_wdata;
        CFG_ITER_LIMIT: cfg_nxt.iter_limit = cfg_wdata[LIMIT_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_real     <= C_REAL_RST;
      cfg_r.c_imag     <= C_IMAG_RST;
      cfg_r.x_origin   <= X_ORIGIN_RST;
      cfg_r.y_origin   <= Y_ORIGIN_RST;
      cfg_r.x_step     <= X_STEP_RST;
      cfg_r.y_step     <= Y_STEP_RST;
      cfg_r.iter_limit <= MAX_ITER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jetp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .pixel_row    (in_pixel_row),
    .pixel_column (in_pixel_column),
    .cfg          (cfg_r),
    .queue_full   (queue_full),
    .busy         (busy),
    .push         (push),
    .push_pt      (push_pt)
  );

  jetp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_pt (push_pt),
    .pop     (pop),
    .full    (queue_full),
    .head    (head)
  );

  jetp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .cfg        (cfg_r),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_color  (out_color)
  );

endmodule

@@ bench/tb_julia_escape_time_pixel_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for julia_escape_time_pixel_top: a directed table, then random
// register settings and pixels; colors checked against a typed value or a Q8.24 predictor
// depends on jetp_pkg and src/julia_escape_time_pixel_top.sv
module tb_julia_escape_time_pixel_top;
  import jetp_pkg::*;

  localparam int     CYCLE_LIMIT     = 4_000_000;
  localparam int     PHASES          = 15;
  localparam int     ITEMS_PER_PHASE = 100;
  localparam int     DRAIN_CYCLES    = 600;
  localparam longint Q_HI            = 64'sd2147483647;
  localparam longint Q_LO            = -64'sd2147483648;
  localparam longint ESCAPE_BOUND    = 64'sd67108864;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam bit ROW_PIX   = 1'b0;
  localparam bit ROW_CFG   = 1'b1;
  localparam bit EXP_MODEL = 1'b0;
  localparam bit EXP_TYPED = 1'b1;

  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [Q_W-1:0]       data;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    bit                   typed;
    logic [COLOR_W-1:0]   color;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_PIX, 3'd0, 32'd0, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_PIX, 3'd0, 32'd0, 11'd2047, 11'd2047, EXP_MODEL, 8'd0},
    '{ROW_PIX, 3'd0, 32'd0, 11'd0, 11'd2047, EXP_MODEL, 8'd0},
    '{ROW_PIX, 3'd0, 32'd0, 11'd1024, 11'd512, EXP_MODEL, 8'd0},
    // zero limit: nothing runs and the color wraps
    '{ROW_CFG, CFG_ITER_LIMIT, 32'd0, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_PIX, 3'd0, 32'd0, 11'd2047, 11'd0, EXP_TYPED, 8'd255},
    '{ROW_CFG, CFG_ITER_LIMIT, 32'd1, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_PIX, 3'd0, 32'd0, 11'd5, 11'd5, EXP_TYPED, 8'd0},
    '{ROW_CFG, CFG_ITER_LIMIT, 32'd2, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_PIX, 3'd0, 32'd0, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    // all-zero plane: z never moves, so the limit alone decides the color
    '{ROW_CFG, CFG_C_REAL, 32'd0, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_CFG, CFG_C_IMAG, 32'd0, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_CFG, CFG_X_ORIGIN, 32'd0, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_CFG, CFG_Y_ORIGIN, 32'd0, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_CFG, CFG_X_STEP, 32'd0, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_CFG, CFG_Y_STEP, 32'd0, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    // limit above 256 clamps to 256
    '{ROW_CFG, CFG_ITER_LIMIT, 32'd511, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_PIX, 3'd0, 32'd0, 11'd2047, 11'd2047, EXP_TYPED, 8'd255},
    // unknown index must leave every register alone
    '{ROW_CFG, CFG_UNUSED, 32'hFFFF_FFFF, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_PIX, 3'd0, 32'd0, 11'd1, 11'd1, EXP_TYPED, 8'd255},
    // saturated start points escape on the first step
    '{ROW_CFG, CFG_X_ORIGIN, 32'h7FFF_FFFF, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_CFG, CFG_X_STEP, 32'h7FFF_FFFF, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_PIX, 3'd0, 32'd0, 11'd0, 11'd2047, EXP_TYPED, 8'd0},
    '{ROW_CFG, CFG_X_ORIGIN, 32'h8000_0000, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_CFG, CFG_X_STEP, 32'h8000_0000, 11'd0, 11'd0, EXP_MODEL, 8'd0},
    '{ROW_PIX, 3'd0, 32'd0, 11'd2047, 11'd2047, EXP_TYPED, 8'd0}
  };

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 start           = 1'b0;
  logic                 busy;
  logic [COORD_W-1:0]   in_pixel_row    = '0;
  logic [COORD_W-1:0]   in_pixel_column = '0;
  logic                 out_strobe;
  logic [COLOR_W-1:0]   out_color;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [Q_W-1:0]       cfg_wdata       = '0;

  // predictor's copy of the register file, reset values loaded
  longint             m_c_real   = longint'(C_REAL_RST);
  longint             m_c_imag   = longint'(C_IMAG_RST);
  longint             m_x_origin = longint'(X_ORIGIN_RST);
  longint             m_y_origin = longint'(Y_ORIGIN_RST);
  longint             m_x_step   = 64'sd8192;
  longint             m_y_step   = 64'sd8192;
  logic [LIMIT_W-1:0] m_limit    = 9'd256;

  logic [COLOR_W-1:0] color_due [$];
  int                 mismatch_count = 0;
  int                 cycle_count    = 0;

  julia_escape_time_pixel_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pixel_row    (in_pixel_row),
    .in_pixel_column (in_pixel_column),
    .out_strobe      (out_strobe),
    .out_color       (out_color),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat_q32(input longint v);
    if (v > Q_HI) begin
      return Q_HI;
    end
    if (v < Q_LO) begin
      return Q_LO;
    end
    return v;
  endfunction

  function automatic longint fx_square(input longint a);
    longint p;
    p = (a * a) >>> 24;
    return (p > Q_HI) ? Q_HI : p;
  endfunction

  function automatic logic [COLOR_W-1:0] escape_color(input logic [COORD_W-1:0] row,
                                                      input logic [COORD_W-1:0] col);
    longint      zr, zi, sr, si, nzi;
    int unsigned lim, cnt;
    zr  = sat_q32(m_x_origin + longint'({53'd0, col}) * m_x_step);
    zi  = sat_q32(m_y_origin + longint'({53'd0, row}) * m_y_step);
    sr  = 0;
    si  = 0;
    cnt = 0;
    lim = (m_limit > 9'd256) ? 256 : int'(m_limit);
    while (sr + si < ESCAPE_BOUND && cnt < lim) begin
      sr  = fx_square(zr);
      si  = fx_square(zi);
      nzi = sat_q32(((zr * zi) >>> 23) + m_c_imag);
      zr  = sat_q32(sr - si + m_c_real);
      zi  = nzi;
      cnt++;
    end
    return 8'(cnt - 1);
  endfunction

  function automatic logic [Q_W-1:0] wild_q32();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // uniform in [-half, +half]
  function automatic logic [Q_W-1:0] span_q24(input int unsigned half);
    return $urandom_range(0, 2 * half) - half;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? 11'd2047 : 11'd0;
    end
    return COORD_W'($urandom_range(0, 2047));
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_C_REAL:     m_c_real   = longint'(signed'(data));
      CFG_C_IMAG:     m_c_imag   = longint'(signed'(data));
      CFG_X_ORIGIN:   m_x_origin = longint'(signed'(data));
      CFG_Y_ORIGIN:   m_y_origin = longint'(signed'(data));
      CFG_X_STEP:     m_x_step   = longint'(signed'(data));
      CFG_Y_STEP:     m_y_step   = longint'(signed'(data));
      CFG_ITER_LIMIT: m_limit    = data[LIMIT_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // start stays high on return when gap is zero, so back-to-back pixels need no dip
  task automatic drive_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                             input int unsigned gap, input bit typed,
                             input logic [COLOR_W-1:0] typed_color);
    start           <= 1'b1;
    in_pixel_row    <= row;
    in_pixel_column <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    color_due.push_back(typed ? typed_color : escape_color(row, col));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (color_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin : color_check
    logic [COLOR_W-1:0] due;
    if (rst_n && out_strobe) begin
      if (color_due.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected color %0d at %0t", out_color, $realtime);
        end
        mismatch_count++;
      end else begin
        due = color_due.pop_front();
        if (out_color !== due) begin
          if (mismatch_count < 10) begin
            $display("color mismatch at %0t: expected %0d, got %0d", $realtime, due,
                     out_color);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_julia_escape_time_pixel_top: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int                 phase, k;
    int unsigned        gap;
    bit                 noisy, no_idle, pause;
    logic [LIMIT_W-1:0] lim;
    logic [Q_W-1:0]     lim_data;
    logic [Q_W-1:0]     hi_bits;
    logic [Q_W-1:0]     cr, ci, xo, yo, xs, ys;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++) begin
      if (DIRECTED[k].is_cfg) begin
        wait_drained();
        cfg_write(DIRECTED[k].idx, DIRECTED[k].data);
      end else begin
        drive_pixel(DIRECTED[k].row, DIRECTED[k].col, $urandom_range(1, 4),
                    DIRECTED[k].typed, DIRECTED[k].color);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      noisy = ($urandom_range(0, 3) == 0);
      if (noisy) begin
        cr = wild_q32();
        ci = wild_q32();
        xo = wild_q32();
        yo = wild_q32();
        xs = wild_q32();
        ys = wild_q32();
      end else begin
        // a plane window of a few units around the origin with both parts of c in [-1, +1]
        cr = span_q24(16777216);
        ci = span_q24(16777216);
        xo = span_q24(33554432);
        yo = span_q24(33554432);
        xs = span_q24(32768);
        ys = span_q24(32768);
      end
      case ($urandom_range(0, 7))
        0: lim = 9'd0;
        1: lim = 9'd1;
        2: lim = 9'd256;
        3: lim = 9'd511;
        4: lim = LIMIT_W'($urandom_range(257, 511));
        5, 6: lim = LIMIT_W'($urandom_range(2, 48));
        default: lim = LIMIT_W'($urandom_range(0, 511));
      endcase
      hi_bits  = $urandom();
      lim_data = noisy ? {hi_bits[Q_W-1:LIMIT_W], lim} : {23'd0, lim};
      cfg_write(CFG_C_REAL, cr);
      cfg_write(CFG_C_IMAG, ci);
      cfg_write(CFG_X_ORIGIN, xo);
      cfg_write(CFG_Y_ORIGIN, yo);
      cfg_write(CFG_X_STEP, xs);
      cfg_write(CFG_Y_STEP, ys);
      cfg_write(CFG_ITER_LIMIT, lim_data);
      if ($urandom_range(0, 2) == 0) begin
        cfg_write(CFG_UNUSED, $urandom());
      end

      no_idle = ($urandom_range(0, 3) == 0);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (no_idle) begin
          gap = 0;
        end else begin
          case ($urandom_range(0, 19))
            0, 1: gap = $urandom_range(10, 60);
            2, 3, 4, 5, 6, 7, 8: gap = $urandom_range(1, 3);
            default: gap = 0;
          endcase
        end
        // hold off now and then until every color is back
        pause = ($urandom_range(0, 49) == 0);
        if ((pause || k == ITEMS_PER_PHASE - 1) && gap == 0) begin
          gap = 1;
        end
        drive_pixel(pick_coord(), pick_coord(), gap, EXP_MODEL, 8'd0);
        if (pause) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && color_due.size() == 0) begin
      $display("tb_julia_escape_time_pixel_top: PASS");
    end else begin
      $display("tb_julia_escape_time_pixel_top: FAIL");
    end
    $finish;
  end

endmodule
